// ===== rtl/core/fct_pkg.sv =====
// types and constants shared by the frustum culling block
`default_nettype none

package fct_pkg;

  // primitive kind carried in the request
  typedef enum logic [1:0] {
    ActPoint  = 2'd0,
    ActSphere = 2'd1,
    ActBox    = 2'd2,
    ActPass   = 2'd3
  } action_e;

  // plane register file
  localparam int unsigned RegCount = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // normals are Q1.14, so d and radius move up by 14 to match the products
  localparam int unsigned NormShift = 14;
  localparam int unsigned ProdW     = 32;
  localparam int unsigned SumW      = 35;

  // one primitive travelling down the chain
  typedef struct packed {
    action_e            action;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;
    logic        [14:0] radius;
    logic               visible;
  } item_t;

  // unpacked plane coefficients
  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [15:0] d;
  } plane_t;

endpackage

`default_nettype wire

// ===== rtl/core/fct_in_if.sv =====
// request channel: one primitive per request
`default_nettype none

interface fct_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic signed [15:0] first_x;
  logic signed [15:0] first_y;
  logic signed [15:0] first_z;
  logic signed [15:0] second_x;
  logic signed [15:0] second_y;
  logic signed [15:0] second_z;
  logic        [14:0] radius;

  modport source (
    output valid, action, first_x, first_y, first_z,
           second_x, second_y, second_z, radius,
    input  ready
  );
  modport sink (
    input  valid, action, first_x, first_y, first_z,
           second_x, second_y, second_z, radius,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/fct_out_if.sv =====
// result channel: visible flag per primitive
`default_nettype none

interface fct_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (
    output valid, visible,
    input  ready
  );
  modport sink (
    input  valid, visible,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/fct_cell.sv =====
// one plane test cell: product stage then sum and compare stage
`default_nettype none

module fct_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  wire fct_pkg::item_t item_i,
  input  wire  [63:0]         plane_i,
  output logic                valid_o,
  input  wire                 ready_i,
  output fct_pkg::item_t      item_o
);

  fct_pkg::plane_t pl;
  logic            is_box;
  logic            pos_x, pos_y, pos_z;
  logic signed [15:0] sel_x, sel_y, sel_z;

  // stage a: products
  logic                                  va_q;
  logic                                  en_a;
  fct_pkg::item_t                        ia_q;
  logic signed [fct_pkg::ProdW-1:0]      px_q, py_q, pz_q;
  logic signed [fct_pkg::ProdW-1:0]      px_d, py_d, pz_d;
  logic signed [15:0]                    d_q;

  // stage b: sum and compare
  logic                                  vb_q;
  logic                                  en_b;
  fct_pkg::item_t                        ib_q, ib_d;
  logic signed [fct_pkg::SumW-1:0]       sum;
  logic signed [fct_pkg::SumW-1:0]       d_ext, r_ext;
  logic                                  culled;

  assign en_b    = !vb_q || ready_i;
  assign en_a    = !va_q || en_b;
  assign ready_o = en_a;

  assign pl     = fct_pkg::plane_t'(plane_i);
  assign is_box = (item_i.action == fct_pkg::ActBox);
  // box takes the maximum where the normal component is strictly positive
  assign pos_x  = !pl.nx[15] && (pl.nx != '0);
  assign pos_y  = !pl.ny[15] && (pl.ny != '0);
  assign pos_z  = !pl.nz[15] && (pl.nz != '0);
  assign sel_x  = (is_box && pos_x) ? item_i.second_x : item_i.first_x;
  assign sel_y  = (is_box && pos_y) ? item_i.second_y : item_i.first_y;
  assign sel_z  = (is_box && pos_z) ? item_i.second_z : item_i.first_z;
  assign px_d   = pl.nx * sel_x;
  assign py_d   = pl.ny * sel_y;
  assign pz_d   = pl.nz * sel_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_a) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && valid_i) begin
      ia_q <= item_i;
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
      d_q  <= pl.d;
    end
  end

  always_comb begin
    d_ext = {{(fct_pkg::SumW-16-fct_pkg::NormShift){d_q[15]}}, d_q,
             {fct_pkg::NormShift{1'b0}}};
    r_ext = '0;
    if (ia_q.action == fct_pkg::ActSphere) begin
      r_ext = {{(fct_pkg::SumW-15-fct_pkg::NormShift){1'b0}}, ia_q.radius,
               {fct_pkg::NormShift{1'b0}}};
    end
    sum = {{(fct_pkg::SumW-fct_pkg::ProdW){px_q[fct_pkg::ProdW-1]}}, px_q}
        + {{(fct_pkg::SumW-fct_pkg::ProdW){py_q[fct_pkg::ProdW-1]}}, py_q}
        + {{(fct_pkg::SumW-fct_pkg::ProdW){pz_q[fct_pkg::ProdW-1]}}, pz_q}
        + d_ext + r_ext;
    case (ia_q.action)
      fct_pkg::ActBox:                     culled = sum[fct_pkg::SumW-1];
      fct_pkg::ActPoint, fct_pkg::ActSphere:
        culled = sum[fct_pkg::SumW-1] || (sum == '0);
      default:                             culled = 1'b0;
    endcase
    ib_d         = ia_q;
    ib_d.visible = ia_q.visible && !culled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b && va_q) begin
      ib_q <= ib_d;
    end
  end

  assign valid_o = vb_q;
  assign item_o  = ib_q;

endmodule

`default_nettype wire

// ===== rtl/core/frustum_cull_test.sv =====
// frustum culling top level: plane registers and a chain of plane test cells
//
//   channel   dir  modport          contents
//   in_req    in   fct_in_if.sink   action, first/second corner, radius
//   out_res   out  fct_out_if.source visible
//   cfg       in   plain write      cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// min(PLANE_COUNT, 6) planes are tested, one cell per plane; one request enters and
// one result leaves every cycle while out_res is ready, and each cell has a
// product stage and a sum/compare stage; the last stage of the last cell is the
// output register
// ready ripples back stage by stage, so bubbles are squeezed out while the
// result side stalls and in_req stays ready until every stage is full
// asynchronous active-low reset clears the stage valid bits and the planes
`default_nettype none

module frustum_cull_test #(
  parameter int unsigned PLANE_COUNT = 6
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  fct_in_if.sink                           in_req,
  fct_out_if.source                        out_res,
  input  wire                              cfg_we_i,
  input  wire  [fct_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [fct_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  // only six plane registers exist
  localparam int unsigned CellCount =
    (PLANE_COUNT < fct_pkg::RegCount) ? PLANE_COUNT : fct_pkg::RegCount;

  // plane registers; the user must write them only while idle, the block does not enforce it
  logic [fct_pkg::CfgDataW-1:0] plane_q [fct_pkg::RegCount];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fct_pkg::RegCount; i++) begin
        plane_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < fct_pkg::RegCount; i++) begin
        // indexes past the list fall through untouched
        if (cfg_idx_i == fct_pkg::CfgIdxW'(i)) begin
          plane_q[i] <= cfg_wdata_i;
        end
      end
    end
  end

  // chain links: link k feeds cell k
  logic           link_valid [CellCount+1];
  logic           link_ready [CellCount+1];
  fct_pkg::item_t link_item  [CellCount+1];

  // request enters with visible set, each cell may clear it
  always_comb begin
    link_item[0].action   = fct_pkg::action_e'(in_req.action);
    link_item[0].first_x  = in_req.first_x;
    link_item[0].first_y  = in_req.first_y;
    link_item[0].first_z  = in_req.first_z;
    link_item[0].second_x = in_req.second_x;
    link_item[0].second_y = in_req.second_y;
    link_item[0].second_z = in_req.second_z;
    link_item[0].radius   = in_req.radius;
    link_item[0].visible  = 1'b1;
  end

  assign link_valid[0] = in_req.valid;
  assign in_req.ready  = link_ready[0];

  for (genvar g = 0; g < CellCount; g++) begin : g_cell
    fct_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[g]),
      .ready_o (link_ready[g]),
      .item_i  (link_item[g]),
      .plane_i (plane_q[g]),
      .valid_o (link_valid[g+1]),
      .ready_i (link_ready[g+1]),
      .item_o  (link_item[g+1])
    );
  end

  // last cell drives the result channel straight from its output register
  assign out_res.valid          = link_valid[CellCount];
  assign out_res.visible        = link_item[CellCount].visible;
  assign link_ready[CellCount]  = out_res.ready;

endmodule

`default_nettype wire

// ===== rtl/core/fct_checker.sv =====
// port-level checks for the frustum culling block, bound to the top level
`default_nettype none

module fct_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_ready_i,
  input wire out_valid_i,
  input wire out_ready_i,
  input wire out_visible_i
);

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before it was taken");

  // a waiting result keeps its flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_visible_i))
    else $error("result flag changed while stalled");

  // with the output free or drained, the chain must take a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("request refused while the output side is free");

  // reset empties the chain at once
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result shown during reset");

endmodule

bind frustum_cull_test fct_checker u_fct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_req.ready),
  .out_valid_i   (out_res.valid),
  .out_ready_i   (out_res.ready),
  .out_visible_i (out_res.visible)
);

`default_nettype wire
